// ----- rtl/u8u16_pkg.sv -----
// UTF-8 to UTF-16LE converter: shared constants and types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package u8u16_pkg;

	localparam int MAX_UNITS = 4;

	localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
	localparam logic [20:0] MAX_CP       = 21'h10FFFF;
	localparam logic [20:0] PLANE1_BASE  = 21'h010000;
	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_CODE   = 8'h80;
	localparam logic [7:0] LEAD2_MASK  = 8'hE0;
	localparam logic [7:0] LEAD2_CODE  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK  = 8'hF0;
	localparam logic [7:0] LEAD3_CODE  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK  = 8'hF8;
	localparam logic [7:0] LEAD4_CODE  = 8'hF0;

	typedef logic [15:0] unit_t;

	typedef struct packed {
		unit_t [MAX_UNITS-1:0] units;
		logic  [2:0]           last_idx;
		logic                  has_out;
		logic                  fin;
	} result_t;

endpackage

// ----- rtl/u8u16_decode.sv -----
// Sequence state and single-pass decode of one UTF-8 byte into up to four UTF-16 units.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          byte_s1,
	input  logic                fin_s1,
	input  logic                adv,
	output u8u16_pkg::result_t  res
);
	import u8u16_pkg::*;

	logic [20:0] bits_q, bits_n, new_bits, cp, cp_off;
	logic [1:0]  bc_q, bc_n, be_q, be_n;
	logic [2:0]  nf, total, total_m1;
	logic [1:0]  mid_n;
	unit_t       mid0, mid1;
	logic        pending, cont, emit;

	always_comb begin
		pending  = (bc_q != 2'd0);
		cont     = ((byte_s1 & CONT_MASK) == CONT_CODE);
		new_bits = {bits_q[14:0], byte_s1[5:0]};
		bits_n   = bits_q;
		bc_n     = bc_q;
		be_n     = be_q;
		nf       = 3'd0;
		mid_n    = 2'd0;
		mid0     = REPL_UNIT;
		mid1     = REPL_UNIT;
		emit     = 1'b0;
		cp       = new_bits;
		cp_off   = cp - PLANE1_BASE;

		if (pending && cont) begin
			bits_n = new_bits;
			if (be_q <= 2'd1) begin
				emit   = 1'b1;
				bits_n = '0;
				bc_n   = 2'd0;
				be_n   = 2'd0;
			end else begin
				be_n = be_q - 2'd1;
				bc_n = bc_q + 2'd1;
			end
		end else begin
			if (pending) begin
				nf     = {1'b0, bc_q};
				bits_n = '0;
				bc_n   = 2'd0;
				be_n   = 2'd0;
			end
			if (byte_s1 < ASCII_LIMIT) begin
				mid_n = 2'd1;
				mid0  = {8'h00, byte_s1};
			end else if ((byte_s1 & LEAD2_MASK) == LEAD2_CODE) begin
				bits_n = {16'd0, byte_s1[4:0]};
				bc_n   = 2'd1;
				be_n   = 2'd1;
			end else if ((byte_s1 & LEAD3_MASK) == LEAD3_CODE) begin
				bits_n = {17'd0, byte_s1[3:0]};
				bc_n   = 2'd1;
				be_n   = 2'd2;
			end else if ((byte_s1 & LEAD4_MASK) == LEAD4_CODE) begin
				bits_n = {18'd0, byte_s1[2:0]};
				bc_n   = 2'd1;
				be_n   = 2'd3;
			end else begin
				mid_n = 2'd1;
			end
		end

		// completed code point: BMP unit, surrogate pair or replacement
		if (emit) begin
			if (cp > MAX_CP) begin
				mid_n = 2'd1;
			end else if (cp >= PLANE1_BASE) begin
				mid_n = 2'd2;
				mid0  = HI_SURR_BASE + {6'd0, cp_off[19:10]};
				mid1  = LO_SURR_BASE + {6'd0, cp_off[9:0]};
			end else begin
				mid_n = 2'd1;
				mid0  = cp[15:0];
			end
		end

		// final byte flushes whatever is still pending
		if (fin_s1) begin
			nf     = nf + {1'b0, bc_n};
			bits_n = '0;
			bc_n   = 2'd0;
			be_n   = 2'd0;
		end

		total    = nf + {1'b0, mid_n};
		total_m1 = total - 3'd1;
		for (int i = 0; i < MAX_UNITS; i++) begin
			if (3'(i) < nf)
				res.units[i] = REPL_UNIT;
			else if (3'(i) == nf)
				res.units[i] = mid0;
			else
				res.units[i] = mid1;
		end
		res.last_idx = {total_m1[1:0], 1'b1};
		res.has_out  = (total != 3'd0);
		res.fin      = fin_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			bc_q   <= 2'd0;
			be_q   <= 2'd0;
		end else if (adv) begin
			bits_q <= bits_n;
			bc_q   <= bc_n;
			be_q   <= be_n;
		end
	end

	a_state_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(bc_q == 2'd0) == (be_q == 2'd0))
		else $error("collected and expected counts disagree");

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && fin_s1) |=> (bc_q == 2'd0))
		else $error("sequence still pending after final byte");

endmodule

// ----- rtl/u8u16_serializer.sv -----
// Result register and byte serializer: sends the UTF-16 units low byte first.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  u8u16_pkg::result_t  res,
	input  logic                utf16_stall,
	output logic                utf16_valid,
	output logic [7:0]          out_byte,
	output logic                run_last,
	output logic                text_end,
	output logic                free
);
	import u8u16_pkg::*;

	result_t    res_s2;
	logic       valid_s2;
	logic [2:0] idx_s2;
	logic       done;
	unit_t      cur;

	assign cur         = res_s2.units[idx_s2[2:1]];
	assign out_byte    = idx_s2[0] ? cur[15:8] : cur[7:0];
	assign run_last    = (idx_s2 == res_s2.last_idx);
	assign text_end    = run_last && res_s2.fin;
	assign utf16_valid = valid_s2;
	assign done        = valid_s2 && !utf16_stall && run_last;
	assign free        = !valid_s2 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= 3'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_s2   <= 3'd0;
		end else if (done) begin
			valid_s2 <= 1'b0;
		end else if (valid_s2 && !utf16_stall) begin
			idx_s2 <= idx_s2 + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_s2 <= res;
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_s2 <= res_s2.last_idx))
		else $error("byte index past end of result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result register loaded while still busy");

endmodule

// ----- rtl/utf8_to_utf16le_converter_top.sv -----
// UTF-8 to UTF-16LE converter, top level: input register, decoder, byte serializer.
// Depends on u8u16_pkg, u8u16_decode and u8u16_serializer.
`timescale 1ns / 1ps

// Usage:
// - UTF-8 channel: text_byte with final_byte, transferred on utf8_valid && !utf8_stall.
//   final_byte marks the last byte of a text and flushes any unfinished sequence.
// - UTF-16 channel: out_byte, run_last, text_end, transferred on
//   utf16_valid && !utf16_stall. Bytes come low byte of each unit first.
//   run_last tags the last byte caused by one input byte; text_end tags the
//   last byte of a text.
// - Path: an input byte is held in the input register until the output side is
//   free, then its result is loaded into the result register and presented.
// - Throughput: the serializer sends one byte per cycle while utf16_stall is low;
//   an input byte produces 2 output bytes for a BMP character, 4 for a
//   surrogate pair and up to 8 for a broken sequence. Bytes that only collect
//   part of a sequence produce no output and are taken once the output is free.
// - Stall: a stalled output holds its byte; once the input register is also
//   occupied, utf8_stall rises until the result register frees up.
// - Reset: clears the pending sequence and drops all queued work.

module utf8_to_utf16le_converter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	input  logic       utf8_valid,
	output logic       utf8_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       text_end,
	output logic       utf16_valid,
	input  logic       utf16_stall
);
	import u8u16_pkg::*;

	logic [7:0] byte_s1;
	logic       fin_s1;
	logic       valid_s1;
	logic       adv;
	logic       free;
	result_t    res;

	assign adv        = valid_s1 && free;
	assign utf8_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!utf8_stall)
			valid_s1 <= utf8_valid;
	end

	always_ff @(posedge clk) begin
		if (utf8_valid && !utf8_stall) begin
			byte_s1 <= text_byte;
			fin_s1  <= final_byte;
		end
	end

	u8u16_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.fin_s1  (fin_s1),
		.adv     (adv),
		.res     (res)
	);

	u8u16_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (adv && res.has_out),
		.res         (res),
		.utf16_stall (utf16_stall),
		.utf16_valid (utf16_valid),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.text_end    (text_end),
		.free        (free)
	);

endmodule
